[rtl/sspc_pkg.sv]
// Shared types, register indexes and saturation helpers for the sprite projection core.
`timescale 1ns / 1ps

package sspc_pkg;

    // Configuration register indexes
    localparam int CFG_IDX_W = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SCREEN_WIDTH   = 3'd0,
        REG_SCREEN_HEIGHT  = 3'd1,
        REG_EYE_OFFSET     = 3'd2,
        REG_VERTICAL_SHIFT = 3'd3,
        REG_HEIGHT_DIV     = 3'd4,
        REG_WIDTH_DIV      = 3'd5
    } t_cfg_idx;

    // One projected sprite
    typedef struct packed {
        logic               invalid;
        logic signed [31:0] depth;
        logic signed [15:0] column;
        logic signed [15:0] vert_offset;
        logic        [15:0] span_height;
        logic        [15:0] span_width;
        logic        [14:0] top_row;
        logic signed [15:0] bottom_row;
        logic        [14:0] left_col;
        logic signed [15:0] right_col;
    } t_result;

    localparam logic signed [64:0] SAT32_HI = 65'sd2147483647;
    localparam logic signed [64:0] SAT32_LO = -SAT32_HI - 65'sd1;

    // Clamp a wide signed value to the signed 32 bit range
    function automatic logic signed [31:0] sat32(input logic signed [64:0] v);
        if (v > SAT32_HI) begin
            return 32'sh7fffffff;
        end else if (v < SAT32_LO) begin
            return 32'sh80000000;
        end
        return v[31:0];
    endfunction

    // Magnitude of a signed 32 bit value; the most negative value maps to 2^31
    function automatic logic [31:0] abs32(input logic signed [31:0] v);
        return v[31] ? (~v + 32'd1) : v;
    endfunction

endpackage

[rtl/sprite_screen_projection_core.sv]
// Top level of the billboard sprite projection pipeline.
`timescale 1ns / 1ps
// Throughput: one sprite per cycle while o_in_stall is low; three bit-per-stage divider
// pipelines (depth, screen terms, span divisors) set the depth, and every stage can take
// a new item each cycle that the pipeline advances. A two-entry output (register plus skid)
// absorbs one more result while a result waits; then o_in_stall holds the input.
// Reset (i_rst_n low, synchronous) empties the pipeline and loads register defaults.

module sprite_screen_projection_core #(
    parameter int FRAC_BITS   = 16,
    parameter int SCREEN_BITS = 12
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [sspc_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [((SCREEN_BITS + 1 > 14) ? SCREEN_BITS + 1 : 14)-1:0] i_cfg_data,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic signed [31:0]            i_object_x,
    input  logic signed [31:0]            i_object_y,
    input  logic signed [31:0]            i_camera_x,
    input  logic signed [31:0]            i_camera_y,
    input  logic signed [31:0]            i_view_dir_x,
    input  logic signed [31:0]            i_view_dir_y,
    input  logic signed [31:0]            i_cam_plane_x,
    input  logic signed [31:0]            i_cam_plane_y,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic                          o_invalid,
    output logic signed [31:0]            o_depth,
    output logic signed [15:0]            o_column,
    output logic signed [15:0]            o_vert_offset,
    output logic [15:0]                   o_span_height,
    output logic [15:0]                   o_span_width,
    output logic [14:0]                   o_top_row,
    output logic signed [15:0]            o_bottom_row,
    output logic [14:0]                   o_left_col,
    output logic signed [15:0]            o_right_col
);

    localparam int F  = FRAC_BITS;
    localparam int S  = SCREEN_BITS;
    localparam int N1 = 32 + F;         // |n| << F
    localparam int N2 = S + 32;         // (W/2)*|ty+tx|, widest of the screen terms
    localparam int N3 = S + 1 + F;      // H << F
    localparam int CW = N2 + 1;         // signed column
    localparam int VW = 15 + F;         // signed vertical offset
    localparam int EW = N2 + 2;         // edge arithmetic

    localparam logic signed [63:0]   RND    = (64'sd1 <<< F) - 64'sd1;
    localparam logic signed [EW-1:0] S16_HI = EW'(32767);
    localparam logic signed [EW-1:0] S16_LO = -S16_HI - EW'(1);
    localparam logic signed [EW-1:0] U15_HI = EW'(32767);

    typedef struct packed {
        logic sgn_x;
        logic sgn_y;
        logic det_zero;
    } t_side1;

    typedef struct packed {
        logic signed [31:0] ty;
        logic               inv;
        logic               csgn;
        logic               vsgn;
    } t_side2;

    typedef struct packed {
        logic signed [31:0]   ty;
        logic                 inv;
        logic signed [CW-1:0] col;
        logic signed [VW-1:0] voff;
        logic signed [EW-1:0] mid;
    } t_side3;

    // Saturate a divider quotient to signed 32 bits with the given sign
    function automatic logic signed [31:0] sat_q1(input logic [N1-1:0] q, input logic neg);
        if (!neg) begin
            if (|q[N1-1:31]) begin
                return 32'sh7fffffff;
            end
            return q[31:0];
        end
        if ((|q[N1-1:32]) || (q[31] && (|q[30:0]))) begin
            return 32'sh80000000;
        end
        return -q[31:0];
    endfunction

    function automatic logic [15:0] sat_s16(input logic signed [EW-1:0] v);
        if (v > S16_HI) begin
            return 16'h7fff;
        end else if (v < S16_LO) begin
            return 16'h8000;
        end
        return v[15:0];
    endfunction

    function automatic logic [14:0] sat_u15(input logic signed [EW-1:0] v);
        if (v < 0) begin
            return 15'd0;
        end else if (v > U15_HI) begin
            return 15'h7fff;
        end
        return v[14:0];
    endfunction

    function automatic logic [15:0] sat_u16(input logic [N3-1:0] v);
        if (|v[N3-1:16]) begin
            return 16'hffff;
        end
        return v[15:0];
    endfunction

    // ---------------- configuration registers ----------------
    logic        [S:0]  r_screen_width;
    logic        [S:0]  r_screen_height;
    logic signed [11:0] r_eye_offset;
    logic signed [13:0] r_vertical_shift;
    logic        [4:0]  r_height_div;
    logic        [4:0]  r_width_div;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_screen_width   <= (S + 1)'(640);
            r_screen_height  <= (S + 1)'(480);
            r_eye_offset     <= '0;
            r_vertical_shift <= '0;
            r_height_div     <= 5'd1;
            r_width_div      <= 5'd1;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                sspc_pkg::REG_SCREEN_WIDTH:   r_screen_width   <= i_cfg_data[S:0];
                sspc_pkg::REG_SCREEN_HEIGHT:  r_screen_height  <= i_cfg_data[S:0];
                sspc_pkg::REG_EYE_OFFSET:     r_eye_offset     <= i_cfg_data[11:0];
                sspc_pkg::REG_VERTICAL_SHIFT: r_vertical_shift <= i_cfg_data[13:0];
                sspc_pkg::REG_HEIGHT_DIV:     r_height_div     <= i_cfg_data[4:0];
                sspc_pkg::REG_WIDTH_DIV:      r_width_div      <= i_cfg_data[4:0];
                default: ;
            endcase
        end
    end

    // ---------------- pipeline advance ----------------
    logic r_skid_vld;
    logic en;
    assign en         = !r_skid_vld;
    assign o_in_stall = r_skid_vld;

    // ---------------- stage 1: sprite relative to camera ----------------
    logic               r1_vld;
    logic signed [31:0] r1_sx, r1_sy, r1_dx, r1_dy, r1_px, r1_py;
    logic signed [32:0] d_sx, d_sy;

    assign d_sx = 33'(i_object_x) - 33'(i_camera_x);
    assign d_sy = 33'(i_object_y) - 33'(i_camera_y);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
        end else if (en) begin
            r1_vld <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_sx <= sspc_pkg::sat32(65'(d_sx));
            r1_sy <= sspc_pkg::sat32(65'(d_sy));
            r1_dx <= i_view_dir_x;
            r1_dy <= i_view_dir_y;
            r1_px <= i_cam_plane_x;
            r1_py <= i_cam_plane_y;
        end
    end

    // ---------------- stage 2: six products ----------------
    logic               r2_vld;
    logic signed [63:0] r2_p [0:5];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_vld <= 1'b0;
        end else if (en) begin
            r2_vld <= r1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r2_p[0] <= r1_dy * r1_sx;
            r2_p[1] <= r1_dx * r1_sy;
            r2_p[2] <= r1_px * r1_sy;
            r2_p[3] <= r1_py * r1_sx;
            r2_p[4] <= r1_px * r1_dy;
            r2_p[5] <= r1_dx * r1_py;
        end
    end

    // ---------------- stage 3: scale back and difference ----------------
    logic               r3_vld;
    logic signed [31:0] r3_nx, r3_ny, r3_det;
    logic signed [63:0] c_q [0:5];

    // Shift each product down, rounding toward zero
    always_comb begin
        for (int j = 0; j < 6; j++) begin
            c_q[j] = (r2_p[j] + (r2_p[j][63] ? RND : 64'sd0)) >>> F;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_vld <= 1'b0;
        end else if (en) begin
            r3_vld <= r2_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r3_nx  <= sspc_pkg::sat32(65'(c_q[0]) - 65'(c_q[1]));
            r3_ny  <= sspc_pkg::sat32(65'(c_q[2]) - 65'(c_q[3]));
            r3_det <= sspc_pkg::sat32(65'(c_q[4]) - 65'(c_q[5]));
        end
    end

    // ---------------- stage 4: magnitudes into the depth divider ----------------
    logic                 r4_vld;
    logic [1:0][N1-1:0]   r4_num;
    logic [1:0][31:0]     r4_den;
    t_side1               r4_side;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_vld <= 1'b0;
        end else if (en) begin
            r4_vld <= r3_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r4_num[0]        <= {sspc_pkg::abs32(r3_nx), F'(0)};
            r4_num[1]        <= {sspc_pkg::abs32(r3_ny), F'(0)};
            r4_den[0]        <= sspc_pkg::abs32(r3_det);
            r4_den[1]        <= sspc_pkg::abs32(r3_det);
            r4_side.sgn_x    <= r3_nx[31] ^ r3_det[31];
            r4_side.sgn_y    <= r3_ny[31] ^ r3_det[31];
            r4_side.det_zero <= (r3_det == 32'sd0);
        end
    end

    logic               q1_vld;
    logic [1:0][N1-1:0] q1_quo;
    t_side1             q1_side;

    sspc_div #(
        .N  (N1),
        .D  (32),
        .L  (2),
        .SW ($bits(t_side1))
    ) u_div_depth (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r4_vld),
        .i_num   (r4_num),
        .i_den   (r4_den),
        .i_side  (r4_side),
        .o_valid (q1_vld),
        .o_quo   (q1_quo),
        .o_side  (q1_side)
    );

    // ---------------- stage 5: saturate tx and depth ----------------
    logic               r5_vld, r5_inv;
    logic signed [31:0] r5_tx, r5_ty;
    logic signed [31:0] n_ty;

    assign n_ty = sat_q1(q1_quo[1], q1_side.sgn_y);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r5_vld <= 1'b0;
        end else if (en) begin
            r5_vld <= q1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r5_tx  <= sat_q1(q1_quo[0], q1_side.sgn_x);
            r5_ty  <= n_ty;
            r5_inv <= q1_side.det_zero || n_ty[31] || (n_ty == 32'sd0);
        end
    end

    // ---------------- stage 6: column sum ----------------
    logic               r6_vld, r6_inv, r6_csgn;
    logic        [31:0] r6_mag;
    logic signed [31:0] r6_ty;
    logic signed [32:0] c_sum, c_nsum;

    assign c_sum  = 33'(r5_ty) + 33'(r5_tx);
    assign c_nsum = -c_sum;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r6_vld <= 1'b0;
        end else if (en) begin
            r6_vld <= r5_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r6_mag  <= c_sum[32] ? c_nsum[31:0] : c_sum[31:0];
            r6_csgn <= c_sum[32];
            r6_ty   <= r5_ty;
            r6_inv  <= r5_inv;
        end
    end

    // ---------------- stage 7: screen term numerators ----------------
    logic               r7_vld;
    logic [2:0][N2-1:0] r7_num;
    logic [2:0][30:0]   r7_den;
    t_side2             r7_side;
    logic [13:0]        c_vmag;

    assign c_vmag = r_vertical_shift[13] ? 14'(-r_vertical_shift) : r_vertical_shift;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r7_vld <= 1'b0;
        end else if (en) begin
            r7_vld <= r6_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r7_num[0]    <= r_screen_width[S:1] * r6_mag;
            r7_num[1]    <= N2'({c_vmag, F'(0)});
            r7_num[2]    <= N2'({r_screen_height, F'(0)});
            r7_den[0]    <= r6_ty[30:0];
            r7_den[1]    <= r6_ty[30:0];
            r7_den[2]    <= r6_ty[30:0];
            r7_side.ty   <= r6_ty;
            r7_side.inv  <= r6_inv;
            r7_side.csgn <= r6_csgn;
            r7_side.vsgn <= r_vertical_shift[13];
        end
    end

    logic               q2_vld;
    logic [2:0][N2-1:0] q2_quo;
    t_side2             q2_side;

    sspc_div #(
        .N  (N2),
        .D  (31),
        .L  (3),
        .SW ($bits(t_side2))
    ) u_div_screen (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r7_vld),
        .i_num   (r7_num),
        .i_den   (r7_den),
        .i_side  (r7_side),
        .o_valid (q2_vld),
        .o_quo   (q2_quo),
        .o_side  (q2_side)
    );

    // ---------------- stage 8: apply signs ----------------
    logic                 r8_vld, r8_inv;
    logic signed [31:0]   r8_ty;
    logic signed [CW-1:0] r8_col;
    logic signed [VW-1:0] r8_voff;
    logic        [N3-1:0] r8_base;
    logic signed [CW-1:0] c_cpos;
    logic signed [VW-1:0] c_vpos;

    assign c_cpos = {1'b0, q2_quo[0]};
    assign c_vpos = {1'b0, q2_quo[1][13+F:0]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r8_vld <= 1'b0;
        end else if (en) begin
            r8_vld <= q2_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r8_col  <= q2_side.csgn ? -c_cpos : c_cpos;
            r8_voff <= q2_side.vsgn ? -c_vpos : c_vpos;
            r8_base <= q2_quo[2][N3-1:0];
            r8_ty   <= q2_side.ty;
            r8_inv  <= q2_side.inv;
        end
    end

    // ---------------- stage 9: row center and span divisors ----------------
    logic               r9_vld;
    logic [1:0][N3-1:0] r9_num;
    logic [1:0][4:0]    r9_den;
    t_side3             r9_side;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r9_vld <= 1'b0;
        end else if (en) begin
            r9_vld <= r8_vld;
        end
    end

    // Treat a zero divisor as one
    always_ff @(posedge i_clk) begin
        if (en) begin
            r9_num[0]    <= r8_base;
            r9_num[1]    <= r8_base;
            r9_den[0]    <= (r_height_div == 5'd0) ? 5'd1 : r_height_div;
            r9_den[1]    <= (r_width_div == 5'd0) ? 5'd1 : r_width_div;
            r9_side.ty   <= r8_ty;
            r9_side.inv  <= r8_inv;
            r9_side.col  <= r8_col;
            r9_side.voff <= r8_voff;
            r9_side.mid  <= signed'(EW'(r_screen_height[S:1])) + EW'(r_eye_offset)
                            + EW'(r8_voff);
        end
    end

    logic               q3_vld;
    logic [1:0][N3-1:0] q3_quo;
    t_side3             q3_side;

    sspc_div #(
        .N  (N3),
        .D  (5),
        .L  (2),
        .SW ($bits(t_side3))
    ) u_div_span (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r9_vld),
        .i_num   (r9_num),
        .i_den   (r9_den),
        .i_side  (r9_side),
        .o_valid (q3_vld),
        .o_quo   (q3_quo),
        .o_side  (q3_side)
    );

    // ---------------- stage 10: raw edges ----------------
    logic                 r10_vld, r10_inv;
    logic signed [31:0]   r10_ty;
    logic signed [CW-1:0] r10_col;
    logic signed [VW-1:0] r10_voff;
    logic        [N3-1:0] r10_hgt, r10_wid;
    logic signed [EW-1:0] r10_top, r10_bot, r10_lft, r10_rgt;
    logic signed [EW-1:0] c_hh, c_hw, c_col;

    assign c_hh  = signed'(EW'(q3_quo[0] >> 1));
    assign c_hw  = signed'(EW'(q3_quo[1] >> 1));
    assign c_col = EW'(q3_side.col);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r10_vld <= 1'b0;
        end else if (en) begin
            r10_vld <= q3_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r10_top  <= q3_side.mid - c_hh;
            r10_bot  <= q3_side.mid + c_hh;
            r10_lft  <= c_col - c_hw;
            r10_rgt  <= c_col + c_hw;
            r10_hgt  <= q3_quo[0];
            r10_wid  <= q3_quo[1];
            r10_col  <= q3_side.col;
            r10_voff <= q3_side.voff;
            r10_ty   <= q3_side.ty;
            r10_inv  <= q3_side.inv;
        end
    end

    // ---------------- final clamps ----------------
    sspc_pkg::t_result    n_res;
    logic signed [EW-1:0] c_sh, c_sw, c_bot, c_rgt;

    assign c_sh = signed'(EW'(r_screen_height));
    assign c_sw = signed'(EW'(r_screen_width));

    always_comb begin
        c_bot = (r10_bot >= c_sh) ? (c_sh - EW'(1)) : r10_bot;
        c_rgt = (r10_rgt >= c_sw) ? (c_sw - EW'(1)) : r10_rgt;
        n_res = '0;
        if (r10_inv) begin
            n_res.invalid = 1'b1;
        end else begin
            n_res.depth       = r10_ty;
            n_res.column      = sat_s16(EW'(r10_col));
            n_res.vert_offset = sat_s16(EW'(r10_voff));
            n_res.span_height = sat_u16(r10_hgt);
            n_res.span_width  = sat_u16(r10_wid);
            n_res.top_row     = sat_u15(r10_top);
            n_res.bottom_row  = sat_s16(c_bot);
            n_res.left_col    = sat_u15(r10_lft);
            n_res.right_col   = sat_s16(c_rgt);
        end
    end

    // ---------------- output register and skid ----------------
    sspc_pkg::t_result r_out, r_skid;
    logic              r_out_vld;
    logic              out_ready;

    assign out_ready = !r_out_vld || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld  <= 1'b0;
            r_skid_vld <= 1'b0;
        end else if (out_ready) begin
            if (r_skid_vld) begin
                r_out_vld  <= 1'b1;
                r_skid_vld <= 1'b0;
            end else begin
                r_out_vld  <= r10_vld;
            end
        end else if (r10_vld && !r_skid_vld) begin
            r_skid_vld <= 1'b1;
        end
    end

    // Hold the result that meets a stalled output in the skid entry
    always_ff @(posedge i_clk) begin
        if (out_ready) begin
            r_out <= r_skid_vld ? r_skid : n_res;
        end else if (!r_skid_vld) begin
            r_skid <= n_res;
        end
    end

    assign o_out_valid   = r_out_vld;
    assign o_invalid     = r_out.invalid;
    assign o_depth       = r_out.depth;
    assign o_column      = r_out.column;
    assign o_vert_offset = r_out.vert_offset;
    assign o_span_height = r_out.span_height;
    assign o_span_width  = r_out.span_width;
    assign o_top_row     = r_out.top_row;
    assign o_bottom_row  = r_out.bottom_row;
    assign o_left_col    = r_out.left_col;
    assign o_right_col   = r_out.right_col;

endmodule

[rtl/sspc_div.sv]
// Pipelined restoring divider, one quotient bit per stage, several lanes and a side payload.
`timescale 1ns / 1ps

module sspc_div #(
    parameter int N  = 48,
    parameter int D  = 32,
    parameter int L  = 2,
    parameter int SW = 8
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_en,
    input  logic                  i_valid,
    input  logic [L-1:0][N-1:0]   i_num,
    input  logic [L-1:0][D-1:0]   i_den,
    input  logic [SW-1:0]         i_side,
    output logic                  o_valid,
    output logic [L-1:0][N-1:0]   o_quo,
    output logic [SW-1:0]         o_side
);

    logic                r_vld  [0:N-1];
    logic [L-1:0][N-1:0] r_num  [0:N-1];
    logic [SW-1:0]       r_side [0:N-1];
    logic [L-1:0][D-1:0] r_rem  [0:N-2];
    logic [L-1:0][D-1:0] r_den  [0:N-2];

    genvar k, l;
    for (k = 0; k < N; k++) begin : g_stage
        logic                in_vld;
        logic [L-1:0][N-1:0] in_num;
        logic [L-1:0][D-1:0] in_rem;
        logic [L-1:0][D-1:0] in_den;
        logic [SW-1:0]       in_side;
        logic [L-1:0][N-1:0] n_num;
        logic [L-1:0][D-1:0] n_rem;

        // Select stage input: ports for the first stage, previous stage otherwise
        if (k == 0) begin : g_first
            assign in_vld  = i_valid;
            assign in_num  = i_num;
            assign in_rem  = '0;
            assign in_den  = i_den;
            assign in_side = i_side;
        end else begin : g_next
            assign in_vld  = r_vld[k-1];
            assign in_num  = r_num[k-1];
            assign in_rem  = r_rem[k-1];
            assign in_den  = r_den[k-1];
            assign in_side = r_side[k-1];
        end

        // Shift in the next dividend bit, subtract when it fits
        for (l = 0; l < L; l++) begin : g_lane
            logic [D:0] trial;
            logic [D:0] diff;
            logic       fits;
            assign trial    = {in_rem[l], in_num[l][N-1]};
            assign diff     = trial - {1'b0, in_den[l]};
            assign fits     = trial >= {1'b0, in_den[l]};
            assign n_rem[l] = fits ? diff[D-1:0] : trial[D-1:0];
            assign n_num[l] = {in_num[l][N-2:0], fits};
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else if (i_en) begin
                r_vld[k] <= in_vld;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_num[k]  <= n_num;
                r_side[k] <= in_side;
            end
        end

        // The last stage needs no remainder or divisor
        if (k < N - 1) begin : g_keep
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_rem[k] <= n_rem;
                    r_den[k] <= in_den;
                end
            end
        end
    end

    assign o_valid = r_vld[N-1];
    assign o_quo   = r_num[N-1];
    assign o_side  = r_side[N-1];

endmodule
